/* rtl/core/bresenham_circle_generator_core_defines.svh */
// Assertion macros shared by the circle generator RTL.
`ifndef BRESENHAM_CIRCLE_GENERATOR_CORE_DEFINES_SVH
`define BRESENHAM_CIRCLE_GENERATOR_CORE_DEFINES_SVH
`ifndef SYNTHESIS
// Checks a property on every rising clock edge outside reset.
`define BCG_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Checks that a condition never holds on a rising clock edge outside reset.
`define BCG_ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define BCG_ASSERT(lbl, clk, rst_n, prop, msg)
`define BCG_ASSERT_NEVER(lbl, clk, rst_n, cond, msg)
`endif
`endif

/* rtl/core/bcg_pkg.sv */
// Shared types and constants of the circle generator.
package bcg_pkg;

  // Width of the emitted pixel coordinates.
  localparam int unsigned OUT_BITS = 14;

  // Points emitted for one request, one per octant.
  localparam int unsigned POINTS_PER_GROUP = 8;

  // Depth of the group queue between the front and back ends.
  localparam int unsigned QUEUE_DEPTH = 2;

  // Decision variable constants of the midpoint scheme.
  localparam int unsigned DEC_INIT  = 3;
  localparam int unsigned DEC_DIAG  = 10;
  localparam int unsigned DEC_AXIAL = 6;
  localparam int unsigned DEC_SHIFT = 2;

  typedef logic [$clog2(POINTS_PER_GROUP)-1:0] point_idx_t;

  typedef enum logic [0:0] {
    REQ_START = 1'b0,
    REQ_STEP  = 1'b1
  } req_type_e;

endpackage

/* rtl/core/bresenham_circle_generator_core.sv */
// Top level of the midpoint circle point generator.
//
//   Channel   Handshake               Payload
//   request   push in / full out      req_type_i, center_x_i, center_y_i, radius_i
//   point     empty out / pop in      pixel_x_o, pixel_y_o, last_of_step_o, circle_done_o
//
// A start or an active step yields eight points, one per cycle from the output register while
// the consumer keeps popping; a step while idle yields none.
// The first point of a request is written into the group queue and then registered into the
// output register once that register is free.
// A two-entry group queue lets requests be taken while earlier points still drain.
// Reset clears the active flag, the queue and the output valid; no clearing pass is needed.
module bresenham_circle_generator_core #(
  parameter int unsigned COORD_BITS = 12
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                push,
  output logic                                full,
  input  logic                                req_type_i,
  input  logic [COORD_BITS-1:0]               center_x_i,
  input  logic [COORD_BITS-1:0]               center_y_i,
  input  logic [COORD_BITS-1:0]               radius_i,
  output logic                                empty,
  input  logic                                pop,
  output logic signed [bcg_pkg::OUT_BITS-1:0] pixel_x_o,
  output logic signed [bcg_pkg::OUT_BITS-1:0] pixel_y_o,
  output logic                                last_of_step_o,
  output logic                                circle_done_o
);
  import bcg_pkg::*;

  localparam int unsigned GW = 4 * COORD_BITS + 3;

  logic          grp_push, grp_pop, grp_empty;
  logic [GW-1:0] grp_in, grp_out;

  // Request intake and recurrence.
  bcg_front #(.COORD_BITS(COORD_BITS)) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .full_i     (full),
    .req_type_i (req_type_i),
    .center_x_i (center_x_i),
    .center_y_i (center_y_i),
    .radius_i   (radius_i),
    .grp_push_o (grp_push),
    .grp_o      (grp_in)
  );

  // Group queue.
  bcg_fifo #(.WIDTH(GW)) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (grp_push),
    .data_i  (grp_in),
    .full_o  (full),
    .pop_i   (grp_pop),
    .empty_o (grp_empty),
    .data_o  (grp_out)
  );

  // Point emission.
  bcg_back #(.COORD_BITS(COORD_BITS)) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .grp_empty_i    (grp_empty),
    .grp_i          (grp_out),
    .grp_pop_o      (grp_pop),
    .empty_o        (empty),
    .pop_i          (pop),
    .pixel_x_o      (pixel_x_o),
    .pixel_y_o      (pixel_y_o),
    .last_of_step_o (last_of_step_o),
    .circle_done_o  (circle_done_o)
  );

endmodule

/* rtl/core/bcg_front.sv */
// Front end: accepts requests and advances the midpoint decision state.
module bcg_front #(
  parameter int unsigned COORD_BITS = 12
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    push_i,
  input  logic                    full_i,
  input  logic                    req_type_i,
  input  logic [COORD_BITS-1:0]   center_x_i,
  input  logic [COORD_BITS-1:0]   center_y_i,
  input  logic [COORD_BITS-1:0]   radius_i,
  output logic                    grp_push_o,
  output logic [4*COORD_BITS+2:0] grp_o
);
  import bcg_pkg::*;

  localparam int unsigned OW = COORD_BITS + 1;
  localparam int unsigned DW = COORD_BITS + 4;

  logic [COORD_BITS-1:0] cx_q, cy_q;
  logic signed [OW-1:0]  x_q, y_q;
  logic signed [DW-1:0]  d_q;
  logic                  active_q;

  logic                  accept, is_start, d_pos, done;
  logic signed [OW-1:0]  x_inc, y_dec, x_n, y_n;
  logic signed [DW-1:0]  x_ext, y_ext, d_start, d_step;

  // A transfer happens when a request is pushed and the queue has room.
  assign accept   = push_i && !full_i;
  assign is_start = (req_type_i == REQ_START);

  // One step of the midpoint recurrence on the current state.
  always_comb begin
    x_inc   = x_q + OW'(1);
    y_dec   = y_q - OW'(1);
    d_pos   = !d_q[DW-1] && (d_q != '0);
    x_n     = x_inc;
    y_n     = d_pos ? y_dec : y_q;
    x_ext   = {{(DW-OW){x_n[OW-1]}}, x_n};
    y_ext   = {{(DW-OW){y_n[OW-1]}}, y_n};
    if (d_pos) begin
      d_step = d_q + ((x_ext - y_ext) <<< DEC_SHIFT) + DW'(DEC_DIAG);
    end else begin
      d_step = d_q + (x_ext <<< DEC_SHIFT) + DW'(DEC_AXIAL);
    end
    d_start = DW'(DEC_INIT) - (DW'(radius_i) << 1);
    done    = (y_n < x_n);
  end

  // A start always yields a group; a step only while a circle is running.
  always_comb begin
    grp_push_o = accept && (is_start || active_q);
    if (is_start) begin
      grp_o = {1'b0, center_x_i, center_y_i, OW'(0), {1'b0, radius_i}};
    end else begin
      grp_o = {done, cx_q, cy_q, x_n, y_n};
    end
  end

  // Circle state registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
      cx_q     <= '0;
      cy_q     <= '0;
      x_q      <= '0;
      y_q      <= '0;
      d_q      <= '0;
    end else if (accept) begin
      if (is_start) begin
        active_q <= 1'b1;
        cx_q     <= center_x_i;
        cy_q     <= center_y_i;
        x_q      <= '0;
        y_q      <= {1'b0, radius_i};
        d_q      <= d_start;
      end else if (active_q) begin
        x_q <= x_n;
        y_q <= y_n;
        d_q <= d_step;
        if (done) begin
          active_q <= 1'b0;
        end
      end
    end
  end

endmodule

/* rtl/core/bcg_fifo.sv */
// Small queue of point groups between the front and back ends.
`include "bresenham_circle_generator_core_defines.svh"
module bcg_fifo #(
  parameter int unsigned WIDTH = 51
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic             empty_o,
  output logic [WIDTH-1:0] data_o
);
  import bcg_pkg::*;

  localparam int unsigned PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);

  logic [WIDTH-1:0] mem_q [QUEUE_DEPTH];
  logic [PW-1:0]    wr_ptr_q, rd_ptr_q;
  logic [CW-1:0]    cnt_q;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == CW'(QUEUE_DEPTH));
  assign empty_o = (cnt_q == '0);
  assign data_o  = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  // Storage write.
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + CW'(1);
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - CW'(1);
      end
    end
  end

  `BCG_ASSERT_NEVER(a_no_push_full, clk_i, rst_ni, push_i && full_o, "group pushed into full queue")
  `BCG_ASSERT_NEVER(a_no_pop_empty, clk_i, rst_ni, pop_i && empty_o, "group popped from empty queue")
  `BCG_ASSERT_NEVER(a_cnt_range, clk_i, rst_ni, cnt_q > CW'(QUEUE_DEPTH), "queue count overflow")

endmodule

/* rtl/core/bcg_back.sv */
// Back end: walks the eight octant mirrors of a group into the output register.
`include "bresenham_circle_generator_core_defines.svh"
module bcg_back #(
  parameter int unsigned COORD_BITS = 12
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                grp_empty_i,
  input  logic [4*COORD_BITS+2:0]             grp_i,
  output logic                                grp_pop_o,
  output logic                                empty_o,
  input  logic                                pop_i,
  output logic signed [bcg_pkg::OUT_BITS-1:0] pixel_x_o,
  output logic signed [bcg_pkg::OUT_BITS-1:0] pixel_y_o,
  output logic                                last_of_step_o,
  output logic                                circle_done_o
);
  import bcg_pkg::*;

  localparam int unsigned OW = COORD_BITS + 1;
  localparam int unsigned GW = 4 * COORD_BITS + 3;
  localparam int unsigned SW = (COORD_BITS + 2 > OUT_BITS) ? COORD_BITS + 2 : OUT_BITS;

  point_idx_t            idx_q;
  logic                  out_valid_q;
  logic                  load, is_last, grp_done;
  logic [COORD_BITS-1:0] cx, cy;
  logic signed [OW-1:0]  gx, gy, ox, oy;
  logic signed [SW-1:0]  cx_ext, cy_ext, ox_ext, oy_ext, px, py;

  // Unpack the group at the head of the queue.
  assign grp_done = grp_i[GW-1];
  assign cx       = grp_i[GW-2 -: COORD_BITS];
  assign cy       = grp_i[GW-2-COORD_BITS -: COORD_BITS];
  assign gx       = grp_i[2*OW-1 -: OW];
  assign gy       = grp_i[OW-1:0];

  // The output register takes a point when it is free or being drained.
  assign load      = !grp_empty_i && (!out_valid_q || pop_i);
  assign is_last   = (idx_q == point_idx_t'(POINTS_PER_GROUP - 1));
  assign grp_pop_o = load && is_last;
  assign empty_o   = !out_valid_q;

  // Mirror the offsets: bit two swaps axes, bits zero and one negate.
  always_comb begin
    ox     = idx_q[2] ? gy : gx;
    oy     = idx_q[2] ? gx : gy;
    cx_ext = SW'(cx);
    cy_ext = SW'(cy);
    ox_ext = {{(SW-OW){ox[OW-1]}}, ox};
    oy_ext = {{(SW-OW){oy[OW-1]}}, oy};
    px     = idx_q[0] ? cx_ext - ox_ext : cx_ext + ox_ext;
    py     = idx_q[1] ? cy_ext - oy_ext : cy_ext + oy_ext;
  end

  // Point index and output valid.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (load) begin
        idx_q <= idx_q + point_idx_t'(1);
      end
      if (load) begin
        out_valid_q <= 1'b1;
      end else if (pop_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Output payload register.
  always_ff @(posedge clk_i) begin
    if (load) begin
      pixel_x_o      <= px[OUT_BITS-1:0];
      pixel_y_o      <= py[OUT_BITS-1:0];
      last_of_step_o <= is_last;
      circle_done_o  <= is_last && grp_done;
    end
  end

  `BCG_ASSERT(a_done_is_last, clk_i, rst_ni, out_valid_q && circle_done_o |-> last_of_step_o, "circle end off group end")
  `BCG_ASSERT(a_idx_wrap, clk_i, rst_ni, grp_pop_o |=> idx_q == '0, "point index not back at zero")
  `BCG_ASSERT_NEVER(a_pop_no_grp, clk_i, rst_ni, grp_pop_o && grp_empty_i, "group pop while none waits")

endmodule

/* test/tb_bresenham_circle_generator_core.sv */
// Testbench for the midpoint circle point generator, checked against a built-in predictor.
`timescale 1ns / 1ps

module tb_bresenham_circle_generator_core;
  import bcg_pkg::*;

  localparam int unsigned COORD_BITS  = 12;
  localparam int unsigned ITEM_TARGET = 260;
  localparam int unsigned QUIET_AFTER = 215;
  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned DRAIN_WAIT  = 20;

  typedef logic [COORD_BITS-1:0] coord_t;
  typedef logic signed [OUT_BITS-1:0] pixel_t;

  typedef struct {
    pixel_t x;
    pixel_t y;
    logic   last_of_step;
    logic   circle_done;
  } point_t;

  // Predicts the points of each request and compares them with the emitted ones.
  class circle_scoreboard;
    point_t             expected_points[$];
    coord_t             center_x;
    coord_t             center_y;
    logic signed [12:0] off_x;
    logic signed [12:0] off_y;
    int                 decision;
    bit                 drawing;
    int                 mismatches;

    function new();
      center_x   = '0;
      center_y   = '0;
      off_x      = '0;
      off_y      = '0;
      decision   = 0;
      drawing    = 1'b0;
      mismatches = 0;
    endfunction

    function void push_point(int px, int py, bit last, bit fin);
      point_t p;
      p.x            = OUT_BITS'(px);
      p.y            = OUT_BITS'(py);
      p.last_of_step = last;
      p.circle_done  = last && fin;
      expected_points.push_back(p);
    endfunction

    // Queues the eight octant-mirrored points of the current offsets.
    function void predict_group(bit fin);
      int cx;
      int cy;
      int x;
      int y;
      cx = int'(center_x);
      cy = int'(center_y);
      x  = int'(off_x);
      y  = int'(off_y);
      push_point(cx + x, cy + y, 1'b0, fin);
      push_point(cx - x, cy + y, 1'b0, fin);
      push_point(cx + x, cy - y, 1'b0, fin);
      push_point(cx - x, cy - y, 1'b0, fin);
      push_point(cx + y, cy + x, 1'b0, fin);
      push_point(cx - y, cy + x, 1'b0, fin);
      push_point(cx + y, cy - x, 1'b0, fin);
      push_point(cx - y, cy - x, 1'b1, fin);
    endfunction

    // Advances the circle state for one accepted request.
    function void note_request(req_type_e kind, coord_t cx, coord_t cy, coord_t r);
      bit fin;
      if (kind == REQ_START) begin
        center_x = cx;
        center_y = cy;
        off_x    = '0;
        off_y    = 13'(r);
        decision = 3 - 2 * int'(r);
        drawing  = 1'b1;
        predict_group(1'b0);
      end else if (drawing) begin
        off_x = off_x + 13'sd1;
        if (decision > 0) begin
          off_y    = off_y - 13'sd1;
          decision = decision + 4 * (int'(off_x) - int'(off_y)) + 10;
        end else begin
          decision = decision + 4 * int'(off_x) + 6;
        end
        fin = off_y < off_x;
        if (fin) begin
          drawing = 1'b0;
        end
        predict_group(fin);
      end
    endfunction

    // Compares one emitted point with the oldest expected point.
    function void check_point(pixel_t px, pixel_t py, logic last, logic fin);
      point_t want;
      if (expected_points.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("Unexpected point: x=%0d y=%0d last=%0b done=%0b", px, py, last, fin);
        end
        return;
      end
      want = expected_points.pop_front();
      if (px !== want.x || py !== want.y || last !== want.last_of_step ||
          fin !== want.circle_done) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("Point mismatch: expected x=%0d y=%0d last=%0b done=%0b,",
                   want.x, want.y, want.last_of_step, want.circle_done,
                   " got x=%0d y=%0d last=%0b done=%0b", px, py, last, fin);
        end
      end
    endfunction
  endclass

  logic      clk_i      = 1'b0;
  logic      rst_ni     = 1'b0;
  logic      push       = 1'b0;
  logic      req_type_i = REQ_START;
  coord_t    center_x_i = '0;
  coord_t    center_y_i = '0;
  coord_t    radius_i   = '0;
  logic      pop        = 1'b0;
  logic      full;
  logic      empty;
  pixel_t    pixel_x_o;
  pixel_t    pixel_y_o;
  logic      last_of_step_o;
  logic      circle_done_o;

  circle_scoreboard sb = new();
  int unsigned      counted = 0;
  int unsigned      cycles  = 0;
  bit               quiet   = 1'b0;

  bresenham_circle_generator_core #(
    .COORD_BITS(COORD_BITS)
  ) uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .push           (push),
    .full           (full),
    .req_type_i     (req_type_i),
    .center_x_i     (center_x_i),
    .center_y_i     (center_y_i),
    .radius_i       (radius_i),
    .empty          (empty),
    .pop            (pop),
    .pixel_x_o      (pixel_x_o),
    .pixel_y_o      (pixel_y_o),
    .last_of_step_o (last_of_step_o),
    .circle_done_o  (circle_done_o)
  );

  always #5 clk_i = ~clk_i;

  // Watchdog against a hung handshake.
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles", cycles);
      $display("TEST FAILED");
      $finish;
    end
  end

  // Every point transfer is checked against the predictor.
  always @(posedge clk_i) begin
    if (rst_ni && pop && !empty) begin
      sb.check_point(pixel_x_o, pixel_y_o, last_of_step_o, circle_done_o);
    end
  end

  // Point side: random bursts of stalls, none near the end.
  initial begin
    @(posedge rst_ni);
    forever begin
      if (!quiet && $urandom_range(0, 3) == 0) begin
        pop <= 1'b0;
        repeat ($urandom_range(1, 13)) @(posedge clk_i);
      end
      pop <= 1'b1;
      repeat ($urandom_range(1, 20)) @(posedge clk_i);
    end
  end

  // Presents one request, waits for its transfer and updates the predictor.
  task automatic send_request(req_type_e kind, coord_t cx, coord_t cy, coord_t r);
    if (!quiet && $urandom_range(0, 4) == 0) begin
      push <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk_i);
    end
    push       <= 1'b1;
    req_type_i <= kind;
    center_x_i <= cx;
    center_y_i <= cy;
    radius_i   <= r;
    @(posedge clk_i);
    while (full) @(posedge clk_i);
    if (kind == REQ_START || sb.drawing) begin
      counted++;
    end
    sb.note_request(kind, cx, cy, r);
    if (counted >= QUIET_AFTER) begin
      quiet = 1'b1;
    end
  endtask

  // Step request whose unused fields carry random bits.
  task automatic send_step();
    send_request(REQ_STEP, coord_t'($urandom), coord_t'($urandom), coord_t'($urandom));
  endtask

  // Starts a circle and steps it until it ends or the step budget runs out.
  task automatic run_circle(coord_t cx, coord_t cy, coord_t r, int max_steps);
    int n;
    n = 0;
    send_request(REQ_START, cx, cy, r);
    while (sb.drawing && n < max_steps) begin
      send_step();
      n++;
    end
  endtask

  // Stimulus: directed corner cases, then random circles with some noise.
  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Step while idle right after reset, with all field bits set.
    send_request(REQ_STEP, '1, '1, '1);
    // Radius zero: centre eight times, then the first step ends the circle.
    run_circle('0, '0, '0, 1);
    send_request(REQ_STEP, '0, '0, '0);
    // Largest centre and radius, cut short by a start while active.
    run_circle('1, '1, '1, 3);
    run_circle('0, '1, 12'd1, 4);
    // Large radius near the origin gives negative coordinates.
    run_circle('0, '0, '1, 2);
    run_circle(12'hAAA, 12'h555, 12'd5, 10);
    run_circle(12'h555, 12'hAAA, 12'hAAA, 1);
    run_circle(12'd2048, 12'd0, 12'd3, 10);

    // Random part: mostly complete circles, some truncated ones and lone steps.
    while (counted < ITEM_TARGET) begin
      case ($urandom_range(0, 9))
        0: send_step();
        1: run_circle(coord_t'($urandom), coord_t'($urandom), coord_t'($urandom),
                      $urandom_range(0, 6));
        default: run_circle(coord_t'($urandom), coord_t'($urandom),
                            coord_t'($urandom_range(0, 24)), 1000);
      endcase
    end
    push <= 1'b0;

    // Drain the remaining points, then allow for late extras.
    while (sb.expected_points.size() != 0) @(posedge clk_i);
    repeat (DRAIN_WAIT) @(posedge clk_i);

    if (sb.mismatches == 0 && sb.expected_points.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

/* filelist.f */
+incdir+rtl/core
rtl/core/bcg_pkg.sv
rtl/core/bcg_front.sv
rtl/core/bcg_fifo.sv
rtl/core/bcg_back.sv
rtl/core/bresenham_circle_generator_core.sv
test/tb_bresenham_circle_generator_core.sv
